>>> rtl/mca_pkg.sv
`timescale 1ns / 1ps
// mca_pkg: widths, limits and shared types of the masked centroid accumulator.
// No dependencies; used by every module of the block.
package mca_pkg;

    localparam int MAX_FRAMES    = 64;
    localparam int FRAME_BITS    = $clog2(MAX_FRAMES);
    localparam int FCNT_BITS     = $clog2(MAX_FRAMES + 1);
    localparam int COORD_BITS    = 10;
    localparam int SAMPLE_BITS   = 16;
    localparam int WSUM_BITS     = 47;
    localparam int MOM_BITS      = 57;
    localparam int PROD_BITS     = COORD_BITS + 1 + SAMPLE_BITS;
    localparam int VOL_BITS      = 32;
    localparam int MASS_BITS     = 64;
    localparam int MASS_SPLIT    = 24;
    localparam int MASS_PBITS    = VOL_BITS + WSUM_BITS;
    localparam int CENT_BITS     = 24;
    localparam int CENT_FRAC     = 8;
    localparam int DIV_LOW       = CENT_BITS - CENT_FRAC;
    localparam int DIV_CNT_BITS  = $clog2(CENT_BITS + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BINARY_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOXEL_VOLUME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_COUNT  = 2'd2;

    localparam logic [CENT_BITS-1:0] CENT_POS_LIM = {1'b0, {(CENT_BITS-1){1'b1}}};
    localparam logic [CENT_BITS-1:0] CENT_NEG_LIM = {1'b1, {(CENT_BITS-1){1'b0}}};
    localparam logic [MASS_BITS-1:0] MASS_POS_LIM = {1'b0, {(MASS_BITS-1){1'b1}}};
    localparam logic [MASS_BITS-1:0] MASS_NEG_LIM = {1'b1, {(MASS_BITS-1){1'b0}}};

    // one store entry: value sum and three coordinate moments
    typedef struct packed {
        logic [WSUM_BITS-1:0] wsum;
        logic [MOM_BITS-1:0]  mx;
        logic [MOM_BITS-1:0]  my;
        logic [MOM_BITS-1:0]  mz;
    } mca_entry_t;

    // request to the store: accumulate a beat or read an entry for draining
    typedef struct packed {
        logic                          acc;
        logic                          rd;
        logic [FRAME_BITS-1:0]         addr;
        logic signed [SAMPLE_BITS-1:0] val;
        logic [COORD_BITS-1:0]         x;
        logic [COORD_BITS-1:0]         y;
        logic [COORD_BITS-1:0]         z;
    } mca_req_t;

endpackage

>>> rtl/mca_store.sv
`timescale 1ns / 1ps
// mca_store: per-frame accumulator memory with read-modify-write and forwarding.
// Depends on mca_pkg.
module mca_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  mca_pkg::mca_req_t   req,
    input  logic                clr,
    output mca_pkg::mca_entry_t rdata
);

    mca_pkg::mca_entry_t mem [mca_pkg::MAX_FRAMES];
    mca_pkg::mca_entry_t q_reg;
    logic                q_vld_reg;

    logic                                   s1_acc_reg;
    logic [mca_pkg::FRAME_BITS-1:0]         s1_frame_reg;
    logic signed [mca_pkg::SAMPLE_BITS-1:0] s1_val_reg;
    logic [mca_pkg::COORD_BITS-1:0]         s1_x_reg;
    logic [mca_pkg::COORD_BITS-1:0]         s1_y_reg;
    logic [mca_pkg::COORD_BITS-1:0]         s1_z_reg;

    logic                           wb_vld_reg;
    logic [mca_pkg::FRAME_BITS-1:0] wb_frame_reg;
    mca_pkg::mca_entry_t            wb_data_reg;

    logic [mca_pkg::MAX_FRAMES-1:0] vld_reg;
    logic [mca_pkg::MAX_FRAMES-1:0] vld_next;

    mca_pkg::mca_entry_t                  base;
    mca_pkg::mca_entry_t                  upd;
    logic signed [mca_pkg::PROD_BITS-1:0] px;
    logic signed [mca_pkg::PROD_BITS-1:0] py;
    logic signed [mca_pkg::PROD_BITS-1:0] pz;

    // the memory reads old data when written at the same edge; the last
    // write is held in the write-back registers and forwarded
    always_comb
    begin
        if (wb_vld_reg && (wb_frame_reg == s1_frame_reg))
            base = wb_data_reg;
        else if (q_vld_reg)
            base = q_reg;
        else
            base = '0;
    end

    assign px = $signed({1'b0, s1_x_reg}) * s1_val_reg;
    assign py = $signed({1'b0, s1_y_reg}) * s1_val_reg;
    assign pz = $signed({1'b0, s1_z_reg}) * s1_val_reg;

    always_comb
    begin
        upd.wsum = base.wsum + {{(mca_pkg::WSUM_BITS-mca_pkg::SAMPLE_BITS){s1_val_reg[
                   mca_pkg::SAMPLE_BITS-1]}}, s1_val_reg};
        upd.mx   = base.mx + {{(mca_pkg::MOM_BITS-mca_pkg::PROD_BITS){px[
                   mca_pkg::PROD_BITS-1]}}, px};
        upd.my   = base.my + {{(mca_pkg::MOM_BITS-mca_pkg::PROD_BITS){py[
                   mca_pkg::PROD_BITS-1]}}, py};
        upd.mz   = base.mz + {{(mca_pkg::MOM_BITS-mca_pkg::PROD_BITS){pz[
                   mca_pkg::PROD_BITS-1]}}, pz};
    end

    assign rdata = base;

    always_comb
    begin
        vld_next = vld_reg;
        if (s1_acc_reg)
            vld_next[s1_frame_reg] = 1'b1;
        if (clr)
            vld_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_acc_reg)
            mem[s1_frame_reg] <= upd;
        if (req.acc || req.rd)
        begin
            q_reg     <= mem[req.addr];
            q_vld_reg <= vld_reg[req.addr];
        end
        s1_frame_reg <= req.addr;
        s1_val_reg   <= req.val;
        s1_x_reg     <= req.x;
        s1_y_reg     <= req.y;
        s1_z_reg     <= req.z;
        wb_frame_reg <= s1_frame_reg;
        wb_data_reg  <= upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_acc_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else
        begin
            s1_acc_reg <= req.acc;
            wb_vld_reg <= s1_acc_reg;
            vld_reg    <= vld_next;
        end
    end

    a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.acc && req.rd))
        else $error("store: accumulate and drain read in the same cycle");

    a_clr_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr && s1_acc_reg))
        else $error("store: clear while a beat is being written back");

    a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> (vld_reg == '0))
        else $error("store: entries still valid after clear");

endmodule

>>> rtl/mca_div.sv
`timescale 1ns / 1ps
// mca_div: restoring divider, one quotient bit per cycle, for a saturated
// signed Q15.8 centroid coordinate. Depends on mca_pkg.
module mca_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mca_pkg::MOM_BITS-1:0]      num,
    input  logic [mca_pkg::WSUM_BITS-1:0]     den,
    input  logic                              neg,
    output logic                              done,
    output logic [mca_pkg::CENT_BITS-1:0]     quotient
);

    localparam int HI_BITS = mca_pkg::MOM_BITS - mca_pkg::DIV_LOW;

    logic                              busy_reg;
    logic                              done_reg;
    logic [mca_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic [mca_pkg::WSUM_BITS-1:0]     rem_reg;
    logic [mca_pkg::WSUM_BITS-1:0]     den_reg;
    logic [mca_pkg::CENT_BITS-1:0]     quo_reg;
    logic [mca_pkg::CENT_BITS-1:0]     shf_reg;
    logic                              neg_reg;
    logic                              ovf_reg;

    logic [mca_pkg::WSUM_BITS-1:0] num_hi;
    logic [mca_pkg::WSUM_BITS:0]   trial;
    logic [mca_pkg::WSUM_BITS:0]   diff;
    logic                          fits;
    logic [mca_pkg::CENT_BITS-1:0] lim;
    logic [mca_pkg::CENT_BITS-1:0] raw;

    // numerator is scaled by 2^8; the part above the quotient width
    // already at or over the divisor means the quotient does not fit
    assign num_hi = {{(mca_pkg::WSUM_BITS-HI_BITS){1'b0}},
                     num[mca_pkg::MOM_BITS-1:mca_pkg::DIV_LOW]};

    assign trial = {rem_reg, shf_reg[mca_pkg::CENT_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    assign lim = neg_reg ? mca_pkg::CENT_NEG_LIM : mca_pkg::CENT_POS_LIM;
    assign raw = (ovf_reg || (quo_reg > lim)) ? lim : quo_reg;
    assign quotient = neg_reg ? (~raw + mca_pkg::CENT_BITS'(1)) : raw;
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_hi;
            den_reg <= den;
            shf_reg <= {num[mca_pkg::DIV_LOW-1:0], {mca_pkg::CENT_FRAC{1'b0}}};
            quo_reg <= '0;
            neg_reg <= neg;
            ovf_reg <= (num_hi >= den);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[mca_pkg::WSUM_BITS-1:0] : trial[mca_pkg::WSUM_BITS-1:0];
            quo_reg <= {quo_reg[mca_pkg::CENT_BITS-2:0], fits};
            shf_reg <= {shf_reg[mca_pkg::CENT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= mca_pkg::DIV_CNT_BITS'(mca_pkg::CENT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - mca_pkg::DIV_CNT_BITS'(1);
            if (cnt_reg == mca_pkg::DIV_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/mca_mass.sv
`timescale 1ns / 1ps
// mca_mass: voxel volume times value sum in two partial products, then
// saturation to signed 64 bits. Depends on mca_pkg.
module mca_mass
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mca_pkg::VOL_BITS-1:0]   volume,
    input  logic [mca_pkg::WSUM_BITS-1:0]  mag,
    input  logic                           neg,
    output logic                           done,
    output logic [mca_pkg::MASS_BITS-1:0]  mass
);

    localparam int LO_BITS = mca_pkg::VOL_BITS + mca_pkg::MASS_SPLIT;
    localparam int HI_BITS = mca_pkg::VOL_BITS + mca_pkg::WSUM_BITS - mca_pkg::MASS_SPLIT;

    typedef enum logic [1:0] {PH_LO, PH_HI, PH_SUM} phase_t;

    phase_t                           phase_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [mca_pkg::VOL_BITS-1:0]     vol_reg;
    logic [mca_pkg::WSUM_BITS-1:0]    mag_reg;
    logic                             neg_reg;
    logic [LO_BITS-1:0]               plo_reg;
    logic [HI_BITS-1:0]               phi_reg;
    logic [mca_pkg::MASS_PBITS-1:0]   prod_reg;

    logic                            ovf;
    logic [mca_pkg::MASS_BITS-1:0]   mag_sat;

    always_comb
    begin
        if (neg_reg)
            ovf = (|prod_reg[mca_pkg::MASS_PBITS-1:mca_pkg::MASS_BITS])
                  || (prod_reg[mca_pkg::MASS_BITS-1]
                      && (|prod_reg[mca_pkg::MASS_BITS-2:0]));
        else
            ovf = |prod_reg[mca_pkg::MASS_PBITS-1:mca_pkg::MASS_BITS-1];
        if (ovf)
            mag_sat = neg_reg ? mca_pkg::MASS_NEG_LIM : mca_pkg::MASS_POS_LIM;
        else
            mag_sat = prod_reg[mca_pkg::MASS_BITS-1:0];
    end

    assign mass = neg_reg ? (~mag_sat + mca_pkg::MASS_BITS'(1)) : mag_sat;
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vol_reg <= volume;
            mag_reg <= mag;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_LO:
                    plo_reg <= vol_reg * mag_reg[mca_pkg::MASS_SPLIT-1:0];
                PH_HI:
                    phi_reg <= vol_reg * mag_reg[mca_pkg::WSUM_BITS-1:mca_pkg::MASS_SPLIT];
                PH_SUM:
                    prod_reg <= {{(mca_pkg::MASS_PBITS-LO_BITS){1'b0}}, plo_reg}
                                + {phi_reg, {mca_pkg::MASS_SPLIT{1'b0}}};
                default:
                    prod_reg <= prod_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LO;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            phase_reg <= PH_LO;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_LO:
                    phase_reg <= PH_HI;
                PH_HI:
                    phase_reg <= PH_SUM;
                PH_SUM:
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                default:
                    phase_reg <= PH_LO;
            endcase
        end
    end

endmodule

>>> rtl/masked_centroid_accumulator_core.sv
`timescale 1ns / 1ps
// Masked centroid accumulator, top level: sequencer, configuration and result
// register. Depends on mca_pkg, mca_store, mca_div and mca_mass.
//
// Usage:
//   Input channel (in_valid / in_stall): one voxel sample per beat. While
//   accumulating the block takes a beat every cycle; a same-frame beat may
//   follow directly, the store forwards the last write-back.
//   A beat with last set is accumulated, then the block drains: for frames
//   0 .. frame_count-1 (a frame_count of 0 acts as 1, one over 64 as 64) it reads
//   the store entry, runs three 24-step dividers and the mass multiplier in
//   parallel, and presents one result beat. Each result passes through read,
//   load, 24 divider steps and capture; the next frame is read only after the
//   receiver has taken the previous result. in_stall stays high from the last
//   beat until the final result has been taken; the store is emptied when that
//   result is taken, by clearing its per-entry valid bits.
//   Output channel (out_valid / out_stall): a result is held in the output
//   register until taken; out_last marks the final frame of the region.
//   Configuration (cfg_write, cfg_index, cfg_data) is to be written by the user only
//   while idle; the block itself does not enforce this. Reset empties the store and
//   loads binary_mode 0, voxel_volume 1.0 mm^3, frame_count 1.
module masked_centroid_accumulator_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write,
    input  logic [mca_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mca_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mca_pkg::FRAME_BITS-1:0]       frame,
    input  logic [mca_pkg::COORD_BITS-1:0]       pos_x,
    input  logic [mca_pkg::COORD_BITS-1:0]       pos_y,
    input  logic [mca_pkg::COORD_BITS-1:0]       pos_z,
    input  logic signed [mca_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 last,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mca_pkg::FRAME_BITS-1:0]       out_frame,
    output logic signed [mca_pkg::CENT_BITS-1:0] center_x,
    output logic signed [mca_pkg::CENT_BITS-1:0] center_y,
    output logic signed [mca_pkg::CENT_BITS-1:0] center_z,
    output logic signed [mca_pkg::MASS_BITS-1:0] mass,
    output logic                                 zero_weight,
    output logic                                 out_last
);

    localparam logic [mca_pkg::VOL_BITS-1:0]     VOL_RESET        = 32'h0001_0000;

    typedef enum logic [2:0] {ST_ACC, ST_READ, ST_LOAD, ST_CALC, ST_OUT} state_t;

    state_t                          state_reg;
    logic [mca_pkg::FRAME_BITS-1:0]  t_reg;
    logic                            zero_reg;
    logic                            binary_mode_reg;
    logic [mca_pkg::VOL_BITS-1:0]    voxel_volume_reg;
    logic [mca_pkg::FCNT_BITS-1:0]   frame_count_reg;

    logic                            out_valid_reg;
    logic [mca_pkg::FRAME_BITS-1:0]  out_frame_reg;
    logic [mca_pkg::CENT_BITS-1:0]   center_x_reg;
    logic [mca_pkg::CENT_BITS-1:0]   center_y_reg;
    logic [mca_pkg::CENT_BITS-1:0]   center_z_reg;
    logic [mca_pkg::MASS_BITS-1:0]   mass_reg;
    logic                            zero_weight_reg;
    logic                            out_last_reg;

    logic [mca_pkg::FCNT_BITS-1:0]   n_frames;
    logic                            in_take;
    logic                            out_take;
    logic                            is_last_frame;
    logic                            clr;
    logic                            start;
    logic                            done_all;
    mca_pkg::mca_req_t               req;
    mca_pkg::mca_entry_t             rdata;

    logic                            sum_neg;
    logic [mca_pkg::WSUM_BITS-1:0]   sum_mag;
    logic                            mx_neg;
    logic                            my_neg;
    logic                            mz_neg;
    logic [mca_pkg::MOM_BITS-1:0]    mx_mag;
    logic [mca_pkg::MOM_BITS-1:0]    my_mag;
    logic [mca_pkg::MOM_BITS-1:0]    mz_mag;

    logic                            dx_done;
    logic                            dy_done;
    logic                            dz_done;
    logic                            m_done;
    logic [mca_pkg::CENT_BITS-1:0]   qx;
    logic [mca_pkg::CENT_BITS-1:0]   qy;
    logic [mca_pkg::CENT_BITS-1:0]   qz;
    logic [mca_pkg::MASS_BITS-1:0]   mass_val;

    always_comb
    begin
        if (frame_count_reg == '0)
            n_frames = mca_pkg::FCNT_BITS'(1);
        else if (frame_count_reg > mca_pkg::FCNT_BITS'(mca_pkg::MAX_FRAMES))
            n_frames = mca_pkg::FCNT_BITS'(mca_pkg::MAX_FRAMES);
        else
            n_frames = frame_count_reg;
    end

    assign in_stall      = (state_reg != ST_ACC);
    assign in_take       = in_valid && !in_stall;
    assign out_take      = out_valid_reg && !out_stall;
    assign is_last_frame = (({1'b0, t_reg} + mca_pkg::FCNT_BITS'(1)) == n_frames);
    assign clr           = (state_reg == ST_OUT) && out_take && out_last_reg;
    assign start         = (state_reg == ST_LOAD);
    assign done_all      = dx_done && dy_done && dz_done && m_done;

    // frames not in use are dropped; their last mark still acts
    always_comb
    begin
        req.acc  = in_take && ({1'b0, frame} < n_frames);
        req.rd   = (state_reg == ST_READ);
        req.addr = req.rd ? t_reg : frame;
        req.val  = (binary_mode_reg && (sample != '0))
                   ? mca_pkg::SAMPLE_BITS'(1) : sample;
        req.x    = pos_x;
        req.y    = pos_y;
        req.z    = pos_z;
    end

    mca_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .clr   (clr),
        .rdata (rdata)
    );

    assign sum_neg = rdata.wsum[mca_pkg::WSUM_BITS-1];
    assign mx_neg  = rdata.mx[mca_pkg::MOM_BITS-1];
    assign my_neg  = rdata.my[mca_pkg::MOM_BITS-1];
    assign mz_neg  = rdata.mz[mca_pkg::MOM_BITS-1];
    assign sum_mag = sum_neg ? (~rdata.wsum + mca_pkg::WSUM_BITS'(1)) : rdata.wsum;
    assign mx_mag  = mx_neg ? (~rdata.mx + mca_pkg::MOM_BITS'(1)) : rdata.mx;
    assign my_mag  = my_neg ? (~rdata.my + mca_pkg::MOM_BITS'(1)) : rdata.my;
    assign mz_mag  = mz_neg ? (~rdata.mz + mca_pkg::MOM_BITS'(1)) : rdata.mz;

    mca_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .num      (mx_mag),
        .den      (sum_mag),
        .neg      (mx_neg ^ sum_neg),
        .done     (dx_done),
        .quotient (qx)
    );

    mca_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .num      (my_mag),
        .den      (sum_mag),
        .neg      (my_neg ^ sum_neg),
        .done     (dy_done),
        .quotient (qy)
    );

    mca_div u_div_z
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .num      (mz_mag),
        .den      (sum_mag),
        .neg      (mz_neg ^ sum_neg),
        .done     (dz_done),
        .quotient (qz)
    );

    mca_mass u_mass
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .volume (voxel_volume_reg),
        .mag    (sum_mag),
        .neg    (sum_neg),
        .done   (m_done),
        .mass   (mass_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ACC;
            t_reg            <= '0;
            zero_reg         <= 1'b0;
            binary_mode_reg  <= 1'b0;
            voxel_volume_reg <= VOL_RESET;
            frame_count_reg  <= mca_pkg::FCNT_BITS'(1);
            out_valid_reg    <= 1'b0;
            out_frame_reg    <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            mass_reg         <= '0;
            zero_weight_reg  <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mca_pkg::CFG_BINARY_MODE:
                        binary_mode_reg <= cfg_data[0];
                    mca_pkg::CFG_VOXEL_VOLUME:
                        voxel_volume_reg <= cfg_data[mca_pkg::VOL_BITS-1:0];
                    mca_pkg::CFG_FRAME_COUNT:
                        frame_count_reg <= cfg_data[mca_pkg::FCNT_BITS-1:0];
                    default:
                        binary_mode_reg <= binary_mode_reg;
                endcase
            end

            unique case (state_reg)
                ST_ACC:
                begin
                    if (in_take && last)
                    begin
                        t_reg     <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                    state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    zero_reg  <= (rdata.wsum == '0);
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (done_all)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_frame_reg   <= t_reg;
                        center_x_reg    <= zero_reg ? '0 : qx;
                        center_y_reg    <= zero_reg ? '0 : qy;
                        center_z_reg    <= zero_reg ? '0 : qz;
                        mass_reg        <= zero_reg ? '0 : mass_val;
                        zero_weight_reg <= zero_reg;
                        out_last_reg    <= is_last_frame;
                        state_reg       <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                            state_reg <= ST_ACC;
                        else
                        begin
                            t_reg     <= t_reg + mca_pkg::FRAME_BITS'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                    state_reg <= ST_ACC;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_frame   = out_frame_reg;
    assign center_x    = center_x_reg;
    assign center_y    = center_y_reg;
    assign center_z    = center_z_reg;
    assign mass        = mass_reg;
    assign zero_weight = zero_weight_reg;
    assign out_last    = out_last_reg;

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("core: input open while a result is pending");

    a_out_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past((state_reg == ST_CALC) && done_all))
        else $error("core: result presented before the arithmetic finished");

    a_frame_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_frame} < n_frames))
        else $error("core: result for a frame outside the frame count");

endmodule
